### rtl/cwpg_pkg.sv
// shared types and constants of the color wheel pixel generator
package cwpg_pkg;

	// field and register widths
	localparam int CFG_W      = 11;
	localparam int COORD_W    = 10;
	localparam int COLOR_W    = 16;
	localparam int IN_TDATA_W = 24;

	// signed offset from the wheel center, vector and unit-circle datapath widths
	localparam int OFS_W = 11;
	localparam int VEC_W = 28;
	localparam int PNT_W = 18;
	localparam int UNI_W = 17;

	// q2.15 constants of the rotation
	localparam logic signed [PNT_W-1:0] GAIN_Q15 = 18'sd19899;
	localparam logic signed [PNT_W-1:0] ONE_Q15  = 18'sd32768;

	// frame size after reset
	localparam int FRAME_RST = 480;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// per-pixel flags that travel down the pipeline
	typedef struct packed {
		logic in_frame;
		logic center;
		logic flip;
	} pix_flags_t;

endpackage

### rtl/color_wheel_pixel_generator_top.sv
// color wheel pixel generator: pixel position in, rgb565 hue wheel color out
//
// One pixel is taken per clock while the output is not stalled. Its color passes
// an input stage, a setup stage, one rotation stage for each CORDIC step, a
// saturation stage, a scaling stage and the output register. A stall at the
// output holds the whole pipeline; one more input beat is still taken into an
// input skid register while a finished color waits. Frame sizes above MAX_DIM
// are treated as MAX_DIM, and positions outside the doubled half grid give
// color 0. Write the frame size registers only while no pixel is in flight.
module color_wheel_pixel_generator_top #(
	parameter int MAX_DIM      = 1024,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [cwpg_pkg::CFG_W-1:0]        cfg_wdata,
	// pixel position stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [cwpg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // col [9:0], row [19:10], zero pad
	// color stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [cwpg_pkg::COLOR_W-1:0]      m_axis_tdata   // color [15:0]
);
	import cwpg_pkg::*;

	localparam int HALF_W = CFG_W - 1;
	localparam int CAP_I  = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
	localparam logic [CFG_W-1:0] CAP_V = CFG_W'(CAP_I);
	localparam logic [HALF_W-1:0] HALF_RST =
		HALF_W'(((FRAME_RST > CAP_I) ? CAP_I : FRAME_RST) / 2);

	// half grid sizes, kept already clamped and halved
	logic [HALF_W-1:0] half_w_q, half_h_q;
	logic [CFG_W-1:0]  cfg_clamped;

	assign cfg_clamped = (cfg_wdata > CAP_V) ? CAP_V : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_w_q <= HALF_RST;
			half_h_q <= HALF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  half_w_q <= cfg_clamped[CFG_W-1:1];
				REG_FRAME_HEIGHT: half_h_q <= cfg_clamped[CFG_W-1:1];
				default:          ;
			endcase
		end
	end

	// pipeline advance: output empty or taken
	logic adv;
	logic vld_s5;
	assign adv = !vld_s5 || m_axis_tready;

	// input skid register, fills when a beat arrives during a stall
	logic                  skid_vld_q;
	logic [COORD_W-1:0]    skid_col_q, skid_row_q;
	logic                  in_vld;
	logic [COORD_W-1:0]    in_col, in_row;

	assign s_axis_tready = !skid_vld_q;
	assign in_vld = skid_vld_q || s_axis_tvalid;
	assign in_col = skid_vld_q ? skid_col_q : s_axis_tdata[COORD_W-1:0];
	assign in_row = skid_vld_q ? skid_row_q : s_axis_tdata[2*COORD_W-1:COORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (adv) begin
			skid_vld_q <= 1'b0;
		end else if (s_axis_tvalid && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && s_axis_tvalid && !skid_vld_q) begin
			skid_col_q <= s_axis_tdata[COORD_W-1:0];
			skid_row_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
		end
	end

	// stage 1: half grid point, range check, offset from center
	logic                   vld_s1;
	logic                   inside_s1;
	logic signed [OFS_W-1:0] dx_s1, dy_s1;
	logic [COORD_W-2:0]     px_x, px_y;

	assign px_x = in_col[COORD_W-1:1];
	assign px_y = in_row[COORD_W-1:1];

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s1 <= ({1'b0, px_x} < half_w_q) && ({1'b0, px_y} < half_h_q);
			dx_s1 <= $signed({2'b00, px_x}) - $signed({2'b00, half_w_q[HALF_W-1:1]});
			dy_s1 <= $signed({2'b00, px_y}) - $signed({2'b00, half_h_q[HALF_W-1:1]});
		end
	end

	// stage 2: fold the left half plane over, scale to the vector format
	localparam int NSTG = CORDIC_STEPS + 1;

	logic                    vld_sc    [0:CORDIC_STEPS];
	pix_flags_t              flags_sc  [0:CORDIC_STEPS];
	logic signed [VEC_W-1:0] vx_sc     [0:CORDIC_STEPS];
	logic signed [VEC_W-1:0] vy_sc     [0:CORDIC_STEPS];
	logic signed [PNT_W-1:0] ux_sc     [0:CORDIC_STEPS];
	logic signed [PNT_W-1:0] uy_sc     [0:CORDIC_STEPS];

	logic                    flip_s1;
	logic signed [OFS_W-1:0] fdx, fdy;

	assign flip_s1 = dx_s1[OFS_W-1];
	assign fdx = flip_s1 ? -dx_s1 : dx_s1;
	assign fdy = flip_s1 ? -dy_s1 : dy_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_sc[0].in_frame <= inside_s1;
			flags_sc[0].center   <= (dx_s1 == '0) && (dy_s1 == '0);
			flags_sc[0].flip     <= flip_s1;
			vx_sc[0] <= {{(VEC_W-16-OFS_W){fdx[OFS_W-1]}}, fdx, 16'b0};
			vy_sc[0] <= {{(VEC_W-16-OFS_W){fdy[OFS_W-1]}}, fdy, 16'b0};
			ux_sc[0] <= GAIN_Q15;
			uy_sc[0] <= '0;
		end
	end

	// rotation stages: one cordic step each, driving vy toward zero
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic up;
		assign up = !vy_sc[i][VEC_W-1];

		always_ff @(posedge clk) begin
			if (adv) begin
				flags_sc[i+1] <= flags_sc[i];
				if (up) begin
					vx_sc[i+1] <= vx_sc[i] + (vy_sc[i] >>> i);
					vy_sc[i+1] <= vy_sc[i] - (vx_sc[i] >>> i);
					ux_sc[i+1] <= ux_sc[i] - (uy_sc[i] >>> i);
					uy_sc[i+1] <= uy_sc[i] + (ux_sc[i] >>> i);
				end else begin
					vx_sc[i+1] <= vx_sc[i] - (vy_sc[i] >>> i);
					vy_sc[i+1] <= vy_sc[i] + (vx_sc[i] >>> i);
					ux_sc[i+1] <= ux_sc[i] + (uy_sc[i] >>> i);
					uy_sc[i+1] <= uy_sc[i] - (ux_sc[i] >>> i);
				end
			end
		end
	end

	// stage 3 (after rotation): unfold, saturate, shift to unsigned 0..65536
	logic                    vld_s3, inside_s3;
	logic [UNI_W-1:0]        uc_s3, us_s3;
	logic signed [PNT_W-1:0] cf, sf, cs, ss;
	pix_flags_t              fl_end;

	assign fl_end = flags_sc[CORDIC_STEPS];
	assign cf = fl_end.flip ? -ux_sc[CORDIC_STEPS] : ux_sc[CORDIC_STEPS];
	assign sf = fl_end.flip ? -uy_sc[CORDIC_STEPS] : uy_sc[CORDIC_STEPS];

	always_comb begin
		if (fl_end.center) begin
			cs = ONE_Q15;
			ss = '0;
		end else begin
			cs = (cf > ONE_Q15) ? ONE_Q15 : ((cf < -ONE_Q15) ? -ONE_Q15 : cf);
			ss = (sf > ONE_Q15) ? ONE_Q15 : ((sf < -ONE_Q15) ? -ONE_Q15 : sf);
		end
	end

	logic signed [PNT_W-1:0] cu, su;
	assign cu = cs + ONE_Q15;
	assign su = ss + ONE_Q15;

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s3 <= fl_end.in_frame;
			uc_s3 <= cu[UNI_W-1:0];
			us_s3 <= su[UNI_W-1:0];
		end
	end

	// stage 4: scale by 255 and keep the top byte
	logic       vld_s4, inside_s4;
	logic [7:0] r_s4, g_s4;
	logic [UNI_W+7:0] r_prod, g_prod;

	assign r_prod = {uc_s3, 8'b0} - {8'b0, uc_s3};
	assign g_prod = {us_s3, 8'b0} - {8'b0, us_s3};

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s4 <= inside_s3;
			r_s4 <= r_prod[23:16];
			g_s4 <= g_prod[23:16];
		end
	end

	// stage 5: blue from the mean of red and green, pack rgb565
	logic [COLOR_W-1:0] color_s5;
	logic [8:0]         rg_sum;
	logic [7:0]         blue;

	assign rg_sum = {1'b0, r_s4} + {1'b0, g_s4};
	assign blue = 8'd255 - rg_sum[8:1];

	always_ff @(posedge clk) begin
		if (adv) begin
			color_s5 <= inside_s4 ? {r_s4[7:3], g_s4[7:2], blue[7:3]} : '0;
		end
	end

	// valid bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k < NSTG; k++) vld_sc[k] <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_sc[0] <= vld_s1;
			for (int k = 1; k < NSTG; k++) vld_sc[k] <= vld_sc[k-1];
			vld_s3 <= vld_sc[CORDIC_STEPS];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = color_s5;

endmodule

### rtl/cwpg_checker.sv
// port-level checks of the color wheel pixel generator, bound to the top level
module cwpg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [cwpg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [cwpg_pkg::COLOR_W-1:0]      m_axis_tdata
);
	import cwpg_pkg::*;

	logic [IN_TDATA_W+COLOR_W-1:0] unused_bits;
	assign unused_bits = {s_axis_tdata, m_axis_tdata} & '0;

	// a blocked color beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("color beat withdrawn while stalled");

	// a blocked color beat keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("color beat changed while stalled");

	// input only backs up behind a waiting color
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input blocked with no color waiting");

	// a taken color frees the input side on the next cycle
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready && !s_axis_tready |=> s_axis_tready)
		else $error("input still blocked after output drained");

endmodule

bind color_wheel_pixel_generator_top cwpg_checker u_cwpg_checker (.*);

### tb/tb.sv
// self-checking testbench for the color wheel pixel generator
`timescale 1ns / 1ps

module tb;
	import cwpg_pkg::*;

	localparam int WHEEL_MAX_DIM = 1024;
	localparam int WHEEL_STEPS   = 16;
	localparam int WHEEL_LATENCY = WHEEL_STEPS + 5;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PLAN_LEN      = 30;
	localparam int PHASES        = 11;
	localparam int PHASE_PIXELS  = 100;

	// rotation constants in q2.15
	localparam longint ROT_GAIN = 19899;
	localparam longint ROT_ONE  = 32768;

	// color of the wheel center: full red, half green
	localparam logic [COLOR_W-1:0] CENTER_COLOR = 16'hFBE8;
	localparam logic [COLOR_W-1:0] BLANK_COLOR  = 16'h0000;

	typedef enum logic [1:0] {
		ROW_PIXEL,
		ROW_WIDTH,
		ROW_HEIGHT
	} plan_kind_e;

	// one directed step: a pixel (a = col, b = row) or a register write (a = value)
	typedef struct packed {
		plan_kind_e           kind;
		logic [CFG_W-1:0]     a;
		logic [COORD_W-1:0]   b;
		logic                 known;
		logic [COLOR_W-1:0]   color;
	} plan_row_t;

	typedef struct {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COLOR_W-1:0] color;
	} pixel_color_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // col [9:0], row [19:10], zero pad
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [COLOR_W-1:0]     m_axis_tdata;   // color [15:0]

	// shadow of the frame size registers
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	pixel_color_t pending_colors[$];
	int           fail_count;
	bit           source_busy;
	bit           sink_busy;
	int           hold_cycles;
	plan_row_t    plan_tab [PLAN_LEN];

	color_wheel_pixel_generator_top #(
		.MAX_DIM      (WHEEL_MAX_DIM),
		.CORDIC_STEPS (WHEEL_STEPS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// expected wheel color of one pixel under the current frame size
	function automatic logic [COLOR_W-1:0] wheel_color(input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row);
		int unsigned w, h, hw, hh, x, y;
		longint dx, dy, vx, vy, px, py, tv, tp, c, s, r, g, b;
		bit flip;
		w = (32'(width_q) > WHEEL_MAX_DIM) ? WHEEL_MAX_DIM : 32'(width_q);
		h = (32'(height_q) > WHEEL_MAX_DIM) ? WHEEL_MAX_DIM : 32'(height_q);
		hw = w / 2;
		hh = h / 2;
		x = 32'(col) >> 1;
		y = 32'(row) >> 1;
		if (x >= hw || y >= hh)
			return BLANK_COLOR;
		dx = longint'(x) - longint'(hw / 2);
		dy = longint'(y) - longint'(hh / 2);
		if (dx == 0 && dy == 0) begin
			c = ROT_ONE;
			s = 0;
		end else begin
			vx = dx * 65536;
			vy = dy * 65536;
			px = ROT_GAIN;
			py = 0;
			flip = (dx < 0);
			// left half plane is turned by pi first
			if (flip) begin
				vx = -vx;
				vy = -vy;
			end
			for (int i = 0; i < WHEEL_STEPS; i++) begin
				tv = vx;
				tp = px;
				if (vy >= 0) begin
					vx = vx + (vy >>> i);
					vy = vy - (tv >>> i);
					px = px - (py >>> i);
					py = py + (tp >>> i);
				end else begin
					vx = vx - (vy >>> i);
					vy = vy + (tv >>> i);
					px = px + (py >>> i);
					py = py - (tp >>> i);
				end
			end
			if (flip) begin
				px = -px;
				py = -py;
			end
			c = (px > ROT_ONE) ? ROT_ONE : ((px < -ROT_ONE) ? -ROT_ONE : px);
			s = (py > ROT_ONE) ? ROT_ONE : ((py < -ROT_ONE) ? -ROT_ONE : py);
		end
		r = (255 * (c + ROT_ONE)) >>> 16;
		g = (255 * (s + ROT_ONE)) >>> 16;
		b = 255 - (r + g) / 2;
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// register write, one cycle of write enable
	task automatic write_frame_reg(input logic idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_q = value;
		else
			height_q = value;
		@(posedge clk);
	endtask

	// offer one pixel position and record its color once the beat is taken
	task automatic offer_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
			input bit known, input logic [COLOR_W-1:0] color);
		int gap;
		pixel_color_t item;
		gap = source_busy ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - 2 * COORD_W){1'b0}}, row, col};
		do @(posedge clk); while (!s_axis_tready);
		item.col   = col;
		item.row   = row;
		item.color = known ? color : wheel_color(col, row);
		pending_colors.push_back(item);
	endtask

	// stop offering and wait for every outstanding color
	task automatic wait_wheel_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_colors.size() != 0);
	endtask

	// color sink: random stalls, long hold-off on request, compare each beat
	initial begin
		int gap;
		pixel_color_t want;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				gap = hold_cycles;
				hold_cycles = 0;
			end else begin
				gap = sink_busy ? 0 : $urandom_range(0, 17);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (pending_colors.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected color beat %h", m_axis_tdata);
			end else begin
				want = pending_colors.pop_front();
				if (m_axis_tdata !== want.color) begin
					fail_count++;
					if (fail_count <= 10)
						$display("color mismatch at col %0d row %0d: expected %h got %h",
							want.col, want.row, want.color, m_axis_tdata);
				end
			end
		end
	end

	// reset, directed table, random phases, final verdict
	initial begin
		int unsigned w_new, h_new, effw, effh, span_x, span_y;
		logic [COORD_W-1:0] pc, pr;
		plan_row_t step;

		fail_count    = 0;
		hold_cycles   = 0;
		source_busy   = 1'b0;
		sink_busy     = 1'b0;
		width_q       = FRAME_RST;
		height_q      = FRAME_RST;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_FRAME_WIDTH;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;

		plan_tab = '{
			// reset frame 480x480, wheel center at half point (120,120)
			'{ROW_PIXEL,  11'd0,    10'd0,    1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd1023, 10'd1023, 1'b1, BLANK_COLOR},
			'{ROW_PIXEL,  11'd240,  10'd240,  1'b1, CENTER_COLOR},
			'{ROW_PIXEL,  11'd241,  10'd241,  1'b1, CENTER_COLOR},
			'{ROW_PIXEL,  11'd479,  10'd479,  1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd480,  10'd0,    1'b1, BLANK_COLOR},
			'{ROW_PIXEL,  11'd0,    10'd480,  1'b1, BLANK_COLOR},
			// pixels on the axes through the center, the left half axis being the angle pi tie
			'{ROW_PIXEL,  11'd0,    10'd240,  1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd479,  10'd240,  1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd240,  10'd0,    1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd240,  10'd479,  1'b0, BLANK_COLOR},
			// oversized registers clamp to the largest frame
			'{ROW_WIDTH,  11'd2047, 10'd0,    1'b0, BLANK_COLOR},
			'{ROW_HEIGHT, 11'd1025, 10'd0,    1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd1023, 10'd1023, 1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd512,  10'd512,  1'b1, CENTER_COLOR},
			'{ROW_PIXEL,  11'd0,    10'd0,    1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd1023, 10'd0,    1'b0, BLANK_COLOR},
			// frames too narrow to hold a half point
			'{ROW_WIDTH,  11'd1,    10'd0,    1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd0,    10'd0,    1'b1, BLANK_COLOR},
			'{ROW_PIXEL,  11'd1,    10'd1,    1'b1, BLANK_COLOR},
			'{ROW_WIDTH,  11'd0,    10'd0,    1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd0,    10'd0,    1'b1, BLANK_COLOR},
			// smallest frame: a single half point that is the center
			'{ROW_WIDTH,  11'd2,    10'd0,    1'b0, BLANK_COLOR},
			'{ROW_HEIGHT, 11'd2,    10'd0,    1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd0,    10'd0,    1'b1, CENTER_COLOR},
			'{ROW_PIXEL,  11'd1,    10'd1,    1'b1, CENTER_COLOR},
			'{ROW_PIXEL,  11'd2,    10'd0,    1'b1, BLANK_COLOR},
			'{ROW_PIXEL,  11'd0,    10'd2,    1'b1, BLANK_COLOR},
			'{ROW_HEIGHT, 11'd1,    10'd0,    1'b0, BLANK_COLOR},
			'{ROW_PIXEL,  11'd0,    10'd0,    1'b1, BLANK_COLOR}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int k = 0; k < PLAN_LEN; k++) begin
			step = plan_tab[k];
			case (step.kind)
				ROW_PIXEL: begin
					offer_pixel(step.a[COORD_W-1:0], step.b, step.known, step.color);
				end
				ROW_WIDTH: begin
					wait_wheel_drained();
					write_frame_reg(REG_FRAME_WIDTH, step.a);
				end
				default: begin
					wait_wheel_drained();
					write_frame_reg(REG_FRAME_HEIGHT, step.a);
				end
			endcase
		end

		// random phases, one frame size each
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin w_new = 2;    h_new = 2;    end
				1: begin w_new = 1024; h_new = 1024; end
				2: begin w_new = 2047; h_new = 3;    end
				3: begin w_new = 3;    h_new = 2047; end
				4: begin w_new = 1;    h_new = 480;  end
				5: begin w_new = 1024; h_new = 2;    end
				9: begin
					w_new = $urandom_range(0, 2047);
					h_new = $urandom_range(0, 2047);
				end
				default: begin
					w_new = $urandom_range(2, 1024);
					h_new = $urandom_range(2, 1024);
				end
			endcase
			// sender pauses here until every color of the last phase is out
			wait_wheel_drained();
			write_frame_reg(REG_FRAME_WIDTH, CFG_W'(w_new));
			write_frame_reg(REG_FRAME_HEIGHT, CFG_W'(h_new));
			effw   = (32'(width_q) > WHEEL_MAX_DIM) ? WHEEL_MAX_DIM : 32'(width_q);
			effh   = (32'(height_q) > WHEEL_MAX_DIM) ? WHEEL_MAX_DIM : 32'(height_q);
			span_x = 2 * (effw / 2);
			span_y = 2 * (effh / 2);
			source_busy = (ph == 1) || ($urandom_range(0, 3) == 0);
			sink_busy   = (ph == 6) || ($urandom_range(0, 3) == 0);
			// long output hold-off while the source keeps pushing
			if (ph == 1)
				hold_cycles = 400;
			for (int k = 0; k < PHASE_PIXELS; k++) begin
				if (span_x > 0 && $urandom_range(0, 9) < 7)
					pc = COORD_W'($urandom_range(0, span_x - 1));
				else
					pc = COORD_W'($urandom_range(0, 1023));
				if (span_y > 0 && $urandom_range(0, 9) < 7)
					pr = COORD_W'($urandom_range(0, span_y - 1));
				else
					pr = COORD_W'($urandom_range(0, 1023));
				offer_pixel(pc, pr, 1'b0, BLANK_COLOR);
			end
		end

		wait_wheel_drained();
		repeat (2 * WHEEL_LATENCY + 10) @(posedge clk);
		if (fail_count == 0 && pending_colors.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/cwpg_pkg.sv
rtl/color_wheel_pixel_generator_top.sv
rtl/cwpg_checker.sv
tb/tb.sv
